### rtl/core/nlqt_pkg.sv
// Package for the neighbour link-quality table: field widths, result codes,
// defaults and the request/response structs of the averaging unit.
// Depends on nothing; used by nlqt_ewma, the top level and the checker.
package nlqt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ADDR_BITS_DEF   = 16;

  localparam int ADDR_FIELD_W = 16;
  localparam int SEQ_W        = 8;
  localparam int ATTR_W       = 16;
  localparam int AVG_W        = 16;
  localparam int ALPHA_W      = 9;
  localparam int SLOT_W       = 4;
  localparam int STATUS_W     = 3;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;

  localparam logic [ALPHA_W-1:0] EWMA_UNITY  = 9'h100;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'h040;
  localparam logic [AVG_W-1:0]   AVG_INIT    = 16'h0100;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED = 3'd0,
    ST_ADDED   = 3'd1,
    ST_DROPPED = 3'd2,
    ST_DUMP    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    logic               valid;
    logic [SEQ_W-1:0]   gap;
    logic [AVG_W-1:0]   avg;
    logic [ALPHA_W-1:0] alpha;
  } ewma_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] avg;
  } ewma_rsp_t;

  // Result beat layout, lowest bits first: slot, address, average, rssi,
  // lqi, four pad bits. The status travels beside it on tuser.
  function automatic logic [OUT_DATA_W-1:0] pack_result(
    logic [SLOT_W-1:0]       slot,
    logic [ADDR_FIELD_W-1:0] addr,
    logic [AVG_W-1:0]        avg,
    logic [ATTR_W-1:0]       rssi,
    logic [ATTR_W-1:0]       lqi
  );
    return {4'b0000, lqi, rssi, avg, addr, slot};
  endfunction

endpackage

### rtl/core/nlqt_table.sv
// Entry store of the neighbour table: one write port, one read port with
// registered read data. Depends on nothing outside this file.
module nlqt_table #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/nlqt_ewma.sv
// Averaging unit: gap*alpha + floor(avg*(256-alpha)/256), saturated to
// 16 bits, over two registered steps. Depends on nlqt_pkg.
module nlqt_ewma (
  input  logic               clk,
  input  logic               rst_n,
  input  nlqt_pkg::ewma_req_t req,
  output nlqt_pkg::ewma_rsp_t rsp
);

  logic        stage1_vld_r;
  logic [16:0] prod_new_r;
  logic [24:0] prod_old_r;
  logic [17:0] sum;

  // products first, register, then add and clamp
  assign sum = {1'b0, prod_new_r} + {1'b0, prod_old_r[24:8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage1_vld_r <= 1'b0;
      rsp.done     <= 1'b0;
    end else begin
      stage1_vld_r <= req.valid;
      rsp.done     <= stage1_vld_r;
    end
    prod_new_r <= 17'(req.gap) * 17'(req.alpha);
    prod_old_r <= 25'(req.avg) * 25'(nlqt_pkg::EWMA_UNITY - req.alpha);
    rsp.avg    <= sum[17:16] != 2'b00 ? {nlqt_pkg::AVG_W{1'b1}} : sum[15:0];
  end

endmodule

### rtl/core/neighbor_link_quality_table_core.sv
// Top level of the neighbour link-quality table: sequencer, result register
// and configuration register. Depends on nlqt_pkg, nlqt_table and nlqt_ewma.
//
// Usage:
//   in_*  : one beat per receive report (in_tuser = 0) or dump request
//           (in_tuser = 1). in_tready is high only while the sequencer idles.
//   out_* : result beats; out_tuser carries the status, out_tlast marks the
//           final beat of one input beat.
//   cfg_* : ewma_alpha, written whenever cfg_wr_en is high; values above 256
//           act as 256.
// Operation:
//   receive : the entries are searched in order for the address; a hit is
//             updated, a miss adds an entry, or is dropped when the table
//             is full; either way one result beat is sent.
//   dump    : the entries are sorted by average through the one write port
//             and the one read port of the entry store, then sent as one
//             result beat each; an empty table gives a single empty beat.
//   The address search and the sort scan read one entry per cycle.
// Reset clears the entry count, the result valid flag and the sequencer, and
// sets ewma_alpha to 64. The entry store is not cleared.
// A stalled receiver holds the result register; the sequencer waits for it
// before loading the next beat, while a new input beat may be accepted as
// soon as the previous one has produced all its beats.
module neighbor_link_quality_table_core #(
  parameter int TABLE_DEPTH = nlqt_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_BITS   = nlqt_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: neighbor_addr[15:0], seqno[23:16], rssi[39:24], lqi[55:40]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [nlqt_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode
  input  logic                            in_tuser,
  // out_tdata: slot[3:0], entry_addr[19:4], avg_gap[35:20],
  //            entry_rssi[51:36], entry_lqi[67:52], pad[71:68]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nlqt_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status[2:0]
  output logic [nlqt_pkg::STATUS_W-1:0]   out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [nlqt_pkg::ALPHA_W-1:0]    cfg_wr_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = (ADDR_BITS < nlqt_pkg::ADDR_FIELD_W) ? ADDR_BITS
                                                              : nlqt_pkg::ADDR_FIELD_W;

  typedef struct packed {
    logic [KEY_W-1:0]            addr;
    logic [nlqt_pkg::SEQ_W-1:0]  seq;
    logic [nlqt_pkg::AVG_W-1:0]  avg;
    logic [nlqt_pkg::ATTR_W-1:0] rssi;
    logic [nlqt_pkg::ATTR_W-1:0] lqi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_MISS,
    S_UPD_GO,
    S_UPD_WAIT,
    S_UPD_WR,
    S_NOTE,
    S_SORT_I,
    S_SORT_HEAD,
    S_SORT_SCAN,
    S_SORT_SWAP1,
    S_SORT_SWAP2,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  state_t                            state_r, state_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [IDX_W-1:0]                  idx_r, idx_nxt;
  logic [IDX_W-1:0]                  j_r, j_nxt;
  logic [IDX_W-1:0]                  at_r, at_nxt;
  logic                              found_r, found_nxt;
  entry_t                            work_r, work_nxt;
  entry_t                            min_r, min_nxt;
  logic [KEY_W-1:0]                  key_r, key_nxt;
  logic [nlqt_pkg::SEQ_W-1:0]        seq_r, seq_nxt;
  logic [nlqt_pkg::ATTR_W-1:0]       rssi_r, rssi_nxt;
  logic [nlqt_pkg::ATTR_W-1:0]       lqi_r, lqi_nxt;
  nlqt_pkg::status_t                 status_r, status_nxt;
  logic [nlqt_pkg::ALPHA_W-1:0]      alpha_r;
  logic                              out_valid_r, out_valid_nxt;
  logic [nlqt_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  nlqt_pkg::status_t                 out_user_r, out_user_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              rd_en;
  logic [IDX_W-1:0]                  rd_addr;
  logic [ENTRY_W-1:0]                rd_raw;
  entry_t                            rd_entry;
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_addr;
  entry_t                            wr_entry;
  nlqt_pkg::ewma_req_t               ewma_req;
  nlqt_pkg::ewma_rsp_t               ewma_rsp;
  logic [nlqt_pkg::ALPHA_W-1:0]      alpha_eff;
  logic                              out_free;
  logic                              in_acc;

  assign rd_entry  = entry_t'(rd_raw);
  assign alpha_eff = (alpha_r > nlqt_pkg::EWMA_UNITY) ? nlqt_pkg::EWMA_UNITY : alpha_r;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  nlqt_table #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(wr_entry)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  nlqt_ewma u_ewma (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ewma_req),
    .rsp   (ewma_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= nlqt_pkg::ALPHA_RESET;
    end else if (cfg_wr_en) begin
      alpha_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    at_nxt        = at_r;
    found_nxt     = found_r;
    work_nxt      = work_r;
    min_nxt       = min_r;
    key_nxt       = key_r;
    seq_nxt       = seq_r;
    rssi_nxt      = rssi_r;
    lqi_nxt       = lqi_r;
    status_nxt    = status_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_entry      = work_r;
    ewma_req      = '0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_acc) begin
          key_nxt  = in_tdata[KEY_W-1:0];
          seq_nxt  = in_tdata[23:16];
          rssi_nxt = in_tdata[39:24];
          lqi_nxt  = in_tdata[55:40];
          idx_nxt  = '0;
          if (in_tuser) begin
            if (count_r == '0) begin
              status_nxt = nlqt_pkg::ST_EMPTY;
              state_nxt  = S_NOTE;
            end else begin
              state_nxt = S_SORT_I;
            end
          end else if (count_r == '0) begin
            state_nxt = S_MISS;
          end else begin
            // issue the read of entry 0 for the search
            rd_en     = 1'b1;
            state_nxt = S_LOOKUP;
          end
        end
      end

      S_LOOKUP: begin
        // compare entry idx, read the next one ahead
        rd_en   = 1'b1;
        rd_addr = idx_r + IDX_W'(1);
        if (rd_entry.addr == key_r) begin
          work_nxt      = rd_entry;
          work_nxt.rssi = rssi_r;
          work_nxt.lqi  = lqi_r;
          status_nxt    = nlqt_pkg::ST_UPDATED;
          state_nxt     = S_UPD_GO;
        end else if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
          state_nxt = S_MISS;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_MISS: begin
        if (count_r == CNT_W'(TABLE_DEPTH)) begin
          status_nxt = nlqt_pkg::ST_DROPPED;
          state_nxt  = S_NOTE;
        end else begin
          idx_nxt       = count_r[IDX_W-1:0];
          count_nxt     = count_r + CNT_W'(1);
          work_nxt.addr = key_r;
          work_nxt.seq  = seq_r - nlqt_pkg::SEQ_W'(1);
          work_nxt.avg  = nlqt_pkg::AVG_INIT;
          work_nxt.rssi = rssi_r;
          work_nxt.lqi  = lqi_r;
          status_nxt    = nlqt_pkg::ST_ADDED;
          state_nxt     = S_UPD_GO;
        end
      end

      S_UPD_GO: begin
        ewma_req.valid = 1'b1;
        ewma_req.gap   = seq_r - work_r.seq;
        ewma_req.avg   = work_r.avg;
        ewma_req.alpha = alpha_eff;
        state_nxt      = S_UPD_WAIT;
      end

      S_UPD_WAIT: begin
        if (ewma_rsp.done) begin
          work_nxt.avg = ewma_rsp.avg;
          work_nxt.seq = seq_r;
          state_nxt    = S_UPD_WR;
        end
      end

      S_UPD_WR: begin
        if (out_free) begin
          wr_en         = 1'b1;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = nlqt_pkg::pack_result(nlqt_pkg::SLOT_W'(idx_r),
                            nlqt_pkg::ADDR_FIELD_W'(work_r.addr), work_r.avg,
                            work_r.rssi, work_r.lqi);
          state_nxt     = S_IDLE;
        end
      end

      S_NOTE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = nlqt_pkg::pack_result('0, '0, '0, '0, '0);
          state_nxt     = S_IDLE;
        end
      end

      S_SORT_I: begin
        rd_en     = 1'b1;
        state_nxt = S_SORT_HEAD;
      end

      S_SORT_HEAD: begin
        work_nxt  = rd_entry;
        min_nxt   = rd_entry;
        at_nxt    = idx_r;
        found_nxt = 1'b0;
        if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
          idx_nxt   = '0;
          state_nxt = S_DUMP_RD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r + IDX_W'(1);
          j_nxt     = idx_r + IDX_W'(1);
          state_nxt = S_SORT_SCAN;
        end
      end

      S_SORT_SCAN: begin
        // keep the first strict minimum
        rd_en   = 1'b1;
        rd_addr = j_r + IDX_W'(1);
        if (rd_entry.avg < min_r.avg) begin
          min_nxt   = rd_entry;
          at_nxt    = j_r;
          found_nxt = 1'b1;
        end
        if (CNT_W'(j_r) + CNT_W'(1) == count_r) begin
          state_nxt = S_SORT_SWAP1;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end

      S_SORT_SWAP1: begin
        if (found_r) begin
          wr_en     = 1'b1;
          wr_entry  = min_r;
          state_nxt = S_SORT_SWAP2;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SORT_I;
        end
      end

      S_SORT_SWAP2: begin
        wr_en     = 1'b1;
        wr_addr   = at_r;
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = S_SORT_I;
      end

      S_DUMP_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (CNT_W'(idx_r) + CNT_W'(1) == count_r);
          out_user_nxt  = nlqt_pkg::ST_DUMP;
          out_data_nxt  = nlqt_pkg::pack_result(nlqt_pkg::SLOT_W'(idx_r),
                            nlqt_pkg::ADDR_FIELD_W'(rd_entry.addr), rd_entry.avg,
                            rd_entry.rssi, rd_entry.lqi);
          if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_DUMP_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    j_r        <= j_nxt;
    at_r       <= at_nxt;
    found_r    <= found_nxt;
    work_r     <= work_nxt;
    min_r      <= min_nxt;
    key_r      <= key_nxt;
    seq_r      <= seq_nxt;
    rssi_r     <= rssi_nxt;
    lqi_r      <= lqi_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

### rtl/core/nlqt_checker.sv
// Port-level checks of the neighbour link-quality table, bound to the top
// level. Depends on nlqt_pkg and neighbor_link_quality_table_core.
module nlqt_assertions (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [nlqt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [nlqt_pkg::STATUS_W-1:0]   out_tuser,
  input logic                            out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // the sequencer is busy in the cycle after every accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // only dump beats can be followed by more beats of the same item
  a_nonlast_is_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == nlqt_pkg::ST_DUMP)
    else $error("non-final beat with status other than dump entry");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == nlqt_pkg::ST_UPDATED
                || out_tuser == nlqt_pkg::ST_ADDED
                || out_tuser == nlqt_pkg::ST_DROPPED
                || out_tuser == nlqt_pkg::ST_DUMP
                || out_tuser == nlqt_pkg::ST_EMPTY)
    else $error("status code out of range");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

endmodule

bind neighbor_link_quality_table_core nlqt_assertions u_nlqt_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
